FILE: design/wbbt_pkg.sv
// Package with the item types, operation codes and number format of the world bounding box transform.
package wbbt_pkg;

   localparam int COORD_WIDTH = 32;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_BOX  = 1'b1
   } operation_type;

   localparam logic [1:0] COL_TRANSLATION = 2'd3;

   typedef struct packed {
      operation_type operation;
      logic [1:0]    column_index;
      coord_type     column_row_x;
      coord_type     column_row_y;
      coord_type     column_row_z;
      coord_type     box_min_x;
      coord_type     box_min_y;
      coord_type     box_min_z;
      coord_type     box_max_x;
      coord_type     box_max_y;
      coord_type     box_max_z;
   } req_type;

   typedef struct packed {
      coord_type world_min_x;
      coord_type world_min_y;
      coord_type world_min_z;
      coord_type world_max_x;
      coord_type world_max_y;
      coord_type world_max_z;
      logic      clipped;
   } rsp_type;

endpackage

FILE: design/world_bounding_box_transform.sv
// World bounding box transform: affine matrix store and four-stage box transform pipeline.
// A box item passes through the input register, the product register, the sum register and the result register.
// Throughput: one item per cycle while rsp_ready is held; stages move independently, so bubbles are absorbed.
// The per-stage cost is set by the eighteen parallel product multipliers in the second stage.
// A load item writes its matrix column as it leaves the input register and yields no result.
// Synchronous reset empties the pipeline and sets the matrix to identity with zero translation.
module world_bounding_box_transform
   import wbbt_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int PW = 2 * COORD_WIDTH;
   localparam int SW = PW + 2;
   localparam coord_type COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam coord_type ONE_VALUE = (FRAC_BITS >= COORD_WIDTH - 1) ? COORD_MAX
                                     : coord_type'(longint'(1) << FRAC_BITS);

   // Floors a full-precision sum and clamps it; the top bit flags clamping.
   function automatic logic [COORD_WIDTH:0] floor_saturate(input logic signed [SW-1:0] sum);
      logic signed [SW-1:0] floored;
      logic [COORD_WIDTH:0] result;
      floored = sum >>> FRAC_BITS;
      if (floored > SW'(COORD_MAX)) begin
         result = {1'b1, COORD_MAX};
      end else if (floored < SW'(COORD_MIN)) begin
         result = {1'b1, COORD_MIN};
      end else begin
         result = {1'b0, floored[COORD_WIDTH-1:0]};
      end
      return result;
   endfunction

   coord_type matrix_ff [3][4];
   coord_type matrix_in [3][4];

   logic    s0_valid_ff;
   logic    s0_valid_in;
   req_type s0_data_ff;

   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic signed [PW-1:0] prod_lo_ff [3][3];
   logic signed [PW-1:0] prod_hi_ff [3][3];
   logic signed [PW-1:0] prod_lo_in [3][3];
   logic signed [PW-1:0] prod_hi_in [3][3];
   coord_type            trans_ff [3];

   logic                 s2_valid_ff;
   logic                 s2_valid_in;
   logic signed [SW-1:0] sum_min_ff [3];
   logic signed [SW-1:0] sum_max_ff [3];
   logic signed [SW-1:0] sum_min_in [3];
   logic signed [SW-1:0] sum_max_in [3];

   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   logic s0_free;
   logic s1_free;
   logic s2_free;
   logic s3_free;
   logic load_write;

   coord_type box_lo [3];
   coord_type box_hi [3];
   coord_type col_val [3];

   assign box_lo[0]  = s0_data_ff.box_min_x;
   assign box_lo[1]  = s0_data_ff.box_min_y;
   assign box_lo[2]  = s0_data_ff.box_min_z;
   assign box_hi[0]  = s0_data_ff.box_max_x;
   assign box_hi[1]  = s0_data_ff.box_max_y;
   assign box_hi[2]  = s0_data_ff.box_max_z;
   assign col_val[0] = s0_data_ff.column_row_x;
   assign col_val[1] = s0_data_ff.column_row_y;
   assign col_val[2] = s0_data_ff.column_row_z;

   assign s3_free   = !rsp_valid_ff || rsp_ready;
   assign s2_free   = !s2_valid_ff || s3_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign s0_free   = !s0_valid_ff || s1_free;
   assign req_ready = s0_free;

   assign load_write = s0_valid_ff && s1_free && (s0_data_ff.operation == OP_LOAD);

   always_comb begin
      s0_valid_in = s0_valid_ff;
      if (s0_free) begin
         s0_valid_in = req_valid;
      end
      s1_valid_in = s1_valid_ff;
      if (s1_free) begin
         s1_valid_in = s0_valid_ff && (s0_data_ff.operation == OP_BOX);
      end
      s2_valid_in = s2_valid_ff;
      if (s2_free) begin
         s2_valid_in = s1_valid_ff;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s3_free) begin
         rsp_valid_in = s2_valid_ff;
      end
   end

   always_comb begin
      matrix_in = matrix_ff;
      if (load_write) begin
         for (int r = 0; r < 3; r++) begin
            matrix_in[r][s0_data_ff.column_index] = col_val[r];
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            prod_lo_in[r][k] = PW'(matrix_ff[r][k]) * PW'(box_lo[k]);
            prod_hi_in[r][k] = PW'(matrix_ff[r][k]) * PW'(box_hi[k]);
         end
      end
   end

   // Floor and clamp are monotonic, so the extreme corners come from the extreme products.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum_min_in[r] = SW'(trans_ff[r]) <<< FRAC_BITS;
         sum_max_in[r] = SW'(trans_ff[r]) <<< FRAC_BITS;
         for (int k = 0; k < 3; k++) begin
            if (prod_lo_ff[r][k] < prod_hi_ff[r][k]) begin
               sum_min_in[r] = sum_min_in[r] + SW'(prod_lo_ff[r][k]);
               sum_max_in[r] = sum_max_in[r] + SW'(prod_hi_ff[r][k]);
            end else begin
               sum_min_in[r] = sum_min_in[r] + SW'(prod_hi_ff[r][k]);
               sum_max_in[r] = sum_max_in[r] + SW'(prod_lo_ff[r][k]);
            end
         end
      end
   end

   always_comb begin
      logic [COORD_WIDTH:0] min_x;
      logic [COORD_WIDTH:0] min_y;
      logic [COORD_WIDTH:0] min_z;
      logic [COORD_WIDTH:0] max_x;
      logic [COORD_WIDTH:0] max_y;
      logic [COORD_WIDTH:0] max_z;
      min_x = floor_saturate(sum_min_ff[0]);
      min_y = floor_saturate(sum_min_ff[1]);
      min_z = floor_saturate(sum_min_ff[2]);
      max_x = floor_saturate(sum_max_ff[0]);
      max_y = floor_saturate(sum_max_ff[1]);
      max_z = floor_saturate(sum_max_ff[2]);
      rsp_data_in.world_min_x = min_x[COORD_WIDTH-1:0];
      rsp_data_in.world_min_y = min_y[COORD_WIDTH-1:0];
      rsp_data_in.world_min_z = min_z[COORD_WIDTH-1:0];
      rsp_data_in.world_max_x = max_x[COORD_WIDTH-1:0];
      rsp_data_in.world_max_y = max_y[COORD_WIDTH-1:0];
      rsp_data_in.world_max_z = max_z[COORD_WIDTH-1:0];
      rsp_data_in.clipped     = min_x[COORD_WIDTH] | min_y[COORD_WIDTH] | min_z[COORD_WIDTH]
                                | max_x[COORD_WIDTH] | max_y[COORD_WIDTH] | max_z[COORD_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
               matrix_ff[r][c] <= (r == c) ? ONE_VALUE : '0;
            end
         end
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         matrix_ff    <= matrix_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_free) begin
         s0_data_ff <= req_data;
      end
      if (s1_free) begin
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
         for (int r = 0; r < 3; r++) begin
            trans_ff[r] <= matrix_ff[r][COL_TRANSLATION];
         end
      end
      if (s2_free) begin
         sum_min_ff <= sum_min_in;
         sum_max_ff <= sum_max_in;
      end
      if (s3_free) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_load_no_result : assert property (@(posedge clock) disable iff (reset)
      load_write |=> !s1_valid_ff)
      else $error("A load item entered the product stage.");

   a_min_not_above_max : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.world_min_x <= rsp_data_ff.world_max_x)
                    && (rsp_data_ff.world_min_y <= rsp_data_ff.world_max_y)
                    && (rsp_data_ff.world_min_z <= rsp_data_ff.world_max_z))
      else $error("World minimum lies above world maximum.");

   a_clipped_at_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.clipped |->
         rsp_data_ff.world_min_x == COORD_MAX || rsp_data_ff.world_min_x == COORD_MIN ||
         rsp_data_ff.world_min_y == COORD_MAX || rsp_data_ff.world_min_y == COORD_MIN ||
         rsp_data_ff.world_min_z == COORD_MAX || rsp_data_ff.world_min_z == COORD_MIN ||
         rsp_data_ff.world_max_x == COORD_MAX || rsp_data_ff.world_max_x == COORD_MIN ||
         rsp_data_ff.world_max_y == COORD_MAX || rsp_data_ff.world_max_y == COORD_MIN ||
         rsp_data_ff.world_max_z == COORD_MAX || rsp_data_ff.world_max_z == COORD_MIN)
      else $error("Clipped result has no coordinate at a bound.");

   a_stalled_stage_holds : assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s2_free |=> s2_valid_ff && $stable(sum_min_ff[0])
                                  && $stable(sum_max_ff[0]))
      else $error("Stalled sum stage lost its item.");

endmodule
